// File: src/itl_pkg.sv
// shared types and codes for the interval table lookup unit
package itl_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK
  } itl_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] start_off;
    logic [WORD_W-1:0] end_off;
    logic [WORD_W-1:0] info_off;
  } itl_entry_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] hit_start;
    logic [WORD_W-1:0] hit_end;
    logic [WORD_W-1:0] info_address;
  } itl_result_t;

endpackage

// File: src/interval_table_lookup_unit.sv
// interval table lookup unit top level
//
//   channel  ports                               transfer
//   in       start, busy, in_*                   start high and busy low
//   out      out_valid, out_*                    out_valid high, one cycle
//   cfg      cfg_we, cfg_index, cfg_data         cfg_we high
//
// a write item is written to the table when it is accepted, and busy stays low
// a lookup holds busy through a PROBE and a CHECK state per table probe, plus a
// final PROBE when the search runs out of entries, set by the read-then-compare
// loop on the single table read port
// the result appears in the first cycle with busy low, when a new item may start
// reset clears control state only; the table is undefined until written
module interval_table_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_action,
  input  logic [itl_pkg::INDEX_W-1:0]         in_entry_index,
  input  logic [itl_pkg::WORD_W-1:0]          in_range_start,
  input  logic [itl_pkg::WORD_W-1:0]          in_range_end,
  input  logic [itl_pkg::WORD_W-1:0]          in_info_offset,
  input  logic [itl_pkg::WORD_W-1:0]          in_query_address,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [itl_pkg::WORD_W-1:0]          out_hit_start,
  output logic [itl_pkg::WORD_W-1:0]          out_hit_end,
  output logic [itl_pkg::WORD_W-1:0]          out_info_address,
  input  logic                                cfg_we,
  input  logic [itl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [itl_pkg::WORD_W-1:0]          cfg_data
);
  import itl_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [WORD_W-1:0]  segment_base_r;
  logic [COUNT_W-1:0] entry_count_r;

  logic        mem_we;
  logic [AW-1:0] mem_wr_addr;
  logic [AW-1:0] mem_rd_addr;
  itl_entry_t  wr_data;
  itl_entry_t  rd_data;
  itl_result_t result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_base_r <= '0;
      entry_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEGMENT_BASE: segment_base_r <= cfg_data;
        REG_ENTRY_COUNT:  entry_count_r  <= cfg_data[COUNT_W-1:0];
        default: begin
          segment_base_r <= segment_base_r;
        end
      endcase
    end
  end

  assign wr_data.start_off = in_range_start;
  assign wr_data.end_off   = in_range_end;
  assign wr_data.info_off  = in_info_offset;

  itl_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data)
  );

  itl_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_search (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .action        (in_action),
    .entry_index   (in_entry_index),
    .query_address (in_query_address),
    .segment_base  (segment_base_r),
    .entry_count   (entry_count_r),
    .rd_data       (rd_data),
    .busy          (busy),
    .mem_we        (mem_we),
    .mem_wr_addr   (mem_wr_addr),
    .mem_rd_addr   (mem_rd_addr),
    .res_valid     (out_valid),
    .result        (result)
  );

  assign out_found        = result.found;
  assign out_hit_start    = result.hit_start;
  assign out_hit_end      = result.hit_end;
  assign out_info_address = result.info_address;

endmodule

// File: src/itl_table_mem.sv
// entry table memory, one write port and one registered read port
module itl_table_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  itl_pkg::itl_entry_t wr_data,
  input  logic [AW-1:0]      rd_addr,
  output itl_pkg::itl_entry_t rd_data
);
  import itl_pkg::*;

  itl_entry_t mem [DEPTH];
  itl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/itl_search.sv
// binary search sequencer over the entry table
module itl_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned AW          = 10,
  parameter int unsigned CW          = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          action,
  input  logic [itl_pkg::INDEX_W-1:0]   entry_index,
  input  logic [itl_pkg::WORD_W-1:0]    query_address,
  input  logic [itl_pkg::WORD_W-1:0]    segment_base,
  input  logic [itl_pkg::COUNT_W-1:0]   entry_count,
  input  itl_pkg::itl_entry_t           rd_data,
  output logic                          busy,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [AW-1:0]                 mem_rd_addr,
  output logic                          res_valid,
  output itl_pkg::itl_result_t          result
);
  import itl_pkg::*;

  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  itl_state_t        state_r, state_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [WORD_W-1:0] rel_r, rel_nxt;
  logic              res_valid_r, res_valid_nxt;
  itl_result_t       result_r, result_nxt;

  logic              accept;
  logic [CW:0]       mid_sum;
  logic [CW-1:0]     mid;
  logic [CW-1:0]     count_clamp;
  logic              below_start;
  logic              past_end;
  logic              more;

  assign accept      = start && (state_r == ST_IDLE);
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid         = mid_sum[CW:1];
  assign more        = lo_r < hi_r;
  assign below_start = rel_r < rd_data.start_off;
  assign past_end    = rel_r >= rd_data.end_off;
  assign count_clamp = (32'(entry_count) > DEPTH32) ? CW'(TABLE_DEPTH) : CW'(entry_count);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && action == ACT_LOOKUP) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_nxt = more ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        state_nxt = (below_start || past_end) ? ST_PROBE : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    rel_nxt       = rel_r;
    res_valid_nxt = 1'b0;
    result_nxt    = result_r;
    mem_we        = 1'b0;
    mem_wr_addr   = AW'(entry_index);
    mem_rd_addr   = AW'(mid);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_LOOKUP) begin
            lo_nxt  = '0;
            hi_nxt  = count_clamp;
            rel_nxt = query_address - segment_base;
          end else begin
            mem_we = 32'(entry_index) < DEPTH32;
          end
        end
      end
      ST_PROBE: begin
        mid_nxt = mid;
        if (!more) begin
          res_valid_nxt = 1'b1;
          result_nxt    = '0;
        end
      end
      ST_CHECK: begin
        if (below_start) begin
          hi_nxt = mid_r;
        end else if (past_end) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          res_valid_nxt           = 1'b1;
          result_nxt.found        = 1'b1;
          result_nxt.hit_start    = rd_data.start_off + segment_base;
          result_nxt.hit_end      = rd_data.end_off + segment_base;
          result_nxt.info_address = rd_data.info_off + segment_base;
        end
      end
      default: begin
        res_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    rel_r    <= rel_nxt;
    result_r <= result_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign res_valid = res_valid_r;
  assign result    = result_r;

endmodule

// File: dv/interval_table_lookup_unit_tb.sv
// self-checking testbench for the interval table lookup unit: directed table, then random phases
module interval_table_lookup_unit_tb;
  import itl_pkg::*;

  localparam int unsigned TBL_DEPTH   = 1024;
  localparam int          RAND_ITEMS  = 350;
  localparam int          SETTLE_CYC  = 4;
  localparam int          TAIL_CYC    = 40;
  localparam int          CYCLE_LIMIT = 500000;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t ALL1 = '1;

  typedef struct {
    logic               action;
    logic [INDEX_W-1:0] index;
    word_t              rstart;
    word_t              rend;
    word_t              info;
    word_t              query;
  } table_op_t;

  typedef enum bit {ROW_OP, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    table_op_t            op;
    logic [CFG_IDX_W-1:0] reg_idx;
    word_t                reg_val;
    bit                   typed;
    itl_result_t          want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_action = ACT_WRITE;
  logic [INDEX_W-1:0]   in_entry_index = '0;
  word_t                in_range_start = '0;
  word_t                in_range_end = '0;
  word_t                in_info_offset = '0;
  word_t                in_query_address = '0;
  logic                 out_valid;
  logic                 out_found;
  word_t                out_hit_start;
  word_t                out_hit_end;
  word_t                out_info_address;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t                cfg_data = '0;

  word_t                tbl_start [TBL_DEPTH];
  word_t                tbl_end   [TBL_DEPTH];
  word_t                tbl_info  [TBL_DEPTH];
  word_t                seg_base = '0;
  logic [COUNT_W-1:0]   live_count = '0;

  word_t                plan_start [TBL_DEPTH];
  word_t                plan_end   [TBL_DEPTH];

  itl_result_t          lookup_answers [$];
  dir_row_t             dir_rows [$];
  int unsigned          path_idx [$];

  int errors    = 0;
  int n_lookups = 0;
  int n_hits    = 0;
  int n_writes  = 0;
  int n_regs    = 0;
  int ops_sent  = 0;
  int cycles    = 0;
  bit burst     = 1'b0;

  interval_table_lookup_unit #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_entry_index   (in_entry_index),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .in_info_offset   (in_info_offset),
    .in_query_address (in_query_address),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_hit_start    (out_hit_start),
    .out_hit_end      (out_hit_end),
    .out_info_address (out_info_address),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int next_gap();
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic itl_result_t search_table(word_t q);
    word_t       rel;
    int unsigned n, lo, hi, mid;
    itl_result_t r;
    bit          hit;
    rel = q - seg_base;
    n = int'(live_count);
    if (n > TBL_DEPTH) n = TBL_DEPTH;
    lo = 0;
    hi = n;
    hit = 1'b0;
    r = '0;
    while (lo < hi && !hit) begin
      mid = (lo + hi) / 2;
      if (rel < tbl_start[mid]) hi = mid;
      else if (rel >= tbl_end[mid]) lo = mid + 1;
      else begin
        hit = 1'b1;
        r.found = 1'b1;
        r.hit_start = tbl_start[mid] + seg_base;
        r.hit_end = tbl_end[mid] + seg_base;
        r.info_address = tbl_info[mid] + seg_base;
      end
    end
    return r;
  endfunction

  function automatic word_t pick_query();
    int unsigned n, k, roll;
    word_t       a, w;
    n = (int'(live_count) > TBL_DEPTH) ? TBL_DEPTH : int'(live_count);
    roll = $urandom_range(0, 99);
    k = (n == 0) ? 0 : $urandom_range(0, n - 1);
    if (n == 0 || roll < 15) return rand64();
    if (roll < 25) return ($urandom_range(0, 1) == 1) ? ALL1 : word_t'(0);
    if (roll < 65) begin
      a = tbl_start[k];
      w = tbl_end[k] - tbl_start[k];
      if (tbl_end[k] > tbl_start[k]) a = a + rand64() % w;
    end else begin
      case ($urandom_range(0, 3))
        0: a = tbl_start[k];
        1: a = tbl_end[k] - word_t'(1);
        2: a = tbl_end[k];
        default: a = tbl_start[k] - word_t'(1);
      endcase
    end
    return a + seg_base;
  endfunction

  // queries that keep the search on the entries filled by load_edge_paths
  function automatic word_t pick_edge_query();
    int unsigned k;
    word_t       a;
    k = path_idx[$urandom_range(0, path_idx.size() - 1)];
    case ($urandom_range(0, 4))
      0: a = word_t'($urandom_range(0, 255));
      1: a = tbl_end[TBL_DEPTH - 1] + word_t'($urandom_range(0, 1000));
      2: a = ALL1;
      3: a = tbl_end[k] - word_t'(1);
      default: a = tbl_start[k] + word_t'($urandom_range(0, 2047));
    endcase
    return a + seg_base;
  endfunction

  function automatic dir_row_t blank_row(row_kind_t k);
    dir_row_t r;
    r.kind = k;
    r.op.action = ACT_LOOKUP;
    r.op.index = INDEX_W'($urandom);
    r.op.rstart = rand64();
    r.op.rend = rand64();
    r.op.info = rand64();
    r.op.query = rand64();
    r.reg_idx = REG_SEGMENT_BASE;
    r.reg_val = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic void row_write(int idx, word_t s, word_t e, word_t i);
    dir_row_t r;
    r = blank_row(ROW_OP);
    r.op.action = ACT_WRITE;
    r.op.index = INDEX_W'(idx);
    r.op.rstart = s;
    r.op.rend = e;
    r.op.info = i;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_lookup(word_t q);
    dir_row_t r;
    r = blank_row(ROW_OP);
    r.op.query = q;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_expect(word_t q, bit f, word_t s, word_t e, word_t i);
    dir_row_t r;
    r = blank_row(ROW_OP);
    r.op.query = q;
    r.typed = 1'b1;
    r.want.found = f;
    r.want.hit_start = s;
    r.want.hit_end = e;
    r.want.info_address = i;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
    dir_row_t r;
    r = blank_row(ROW_REG);
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_op(table_op_t op, int gap, bit typed, itl_result_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= op.action;
    in_entry_index <= op.index;
    in_range_start <= op.rstart;
    in_range_end <= op.rend;
    in_info_offset <= op.info;
    in_query_address <= op.query;
    do @(posedge clk); while (busy);
    ops_sent++;
    if (op.action == ACT_WRITE) begin
      tbl_start[op.index] = op.rstart;
      tbl_end[op.index] = op.rend;
      tbl_info[op.index] = op.info;
      n_writes++;
    end else begin
      lookup_answers.push_back(typed ? want : search_table(op.query));
      n_lookups++;
    end
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    do @(posedge clk); while (lookup_answers.size() != 0 || busy);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
    go_quiet();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEGMENT_BASE) seg_base = val;
    else live_count = val[COUNT_W-1:0];
    n_regs++;
  endtask

  // layouts: 0 sorted from zero, 1 sorted ending at the top, 2 sorted at random base,
  // 3 scrambled and overlapping
  task automatic load_table(int n, int layout);
    word_t       cur, width, gap;
    int unsigned sh;
    int          k;
    bit          desc;
    table_op_t   op;
    sh = $urandom_range(0, 24);
    desc = ($urandom_range(0, 1) == 1);
    cur = (layout == 1) ? ALL1 : (layout == 0) ? word_t'(0) : (rand64() >> 1);
    for (int j = 0; j < n; j++) begin
      k = (layout == 1) ? n - 1 - j : j;
      width = word_t'($urandom_range(1, 1 << sh));
      gap = ($urandom_range(0, 3) == 0) ? word_t'(0) : word_t'($urandom_range(0, 1 << sh));
      if (layout == 3) begin
        plan_start[k] = word_t'($urandom_range(0, 4095));
        plan_end[k] = plan_start[k] + word_t'($urandom_range(0, 2048));
      end else if (layout == 1) begin
        plan_end[k] = cur;
        plan_start[k] = cur - width;
        cur = plan_start[k] - gap;
      end else begin
        plan_start[k] = cur;
        plan_end[k] = cur + width;
        cur = plan_end[k] + gap;
      end
    end
    for (int j = 0; j < n; j++) begin
      k = desc ? n - 1 - j : j;
      op.action = ACT_WRITE;
      op.index = INDEX_W'(k);
      op.rstart = plan_start[k];
      op.rend = plan_end[k];
      op.info = rand64();
      op.query = rand64();
      send_op(op, next_gap(), 1'b0, '0);
    end
  endtask

  // fills the entries probed by a full-depth search that keeps going left or right
  task automatic load_edge_paths();
    int unsigned lo, hi, mid;
    table_op_t   op;
    path_idx.delete();
    lo = 0;
    hi = TBL_DEPTH;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      path_idx.push_back(mid);
      hi = mid;
    end
    lo = TBL_DEPTH / 2 + 1;
    hi = TBL_DEPTH;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      path_idx.push_back(mid);
      lo = mid + 1;
    end
    foreach (path_idx[j]) begin
      op.action = ACT_WRITE;
      op.index = INDEX_W'(path_idx[j]);
      op.rstart = (word_t'(path_idx[j]) << 12) + word_t'(256);
      op.rend = op.rstart + word_t'(2048);
      op.info = rand64();
      op.query = rand64();
      send_op(op, next_gap(), 1'b0, '0);
    end
  endtask

  task automatic run_edge_lookups(int count);
    table_op_t op;
    for (int j = 0; j < count; j++) begin
      op.action = ACT_LOOKUP;
      op.index = INDEX_W'($urandom);
      op.rstart = rand64();
      op.rend = rand64();
      op.info = rand64();
      op.query = pick_edge_query();
      send_op(op, next_gap(), 1'b0, '0);
    end
  endtask

  task automatic run_lookups(int count);
    table_op_t op;
    int        roll;
    for (int j = 0; j < count; j++) begin
      op.action = ACT_LOOKUP;
      op.index = INDEX_W'($urandom);
      op.rstart = rand64();
      op.rend = rand64();
      op.info = rand64();
      op.query = pick_query();
      roll = $urandom_range(0, 99);
      if (roll < 10) op.action = ACT_WRITE;
      else if (roll < 18) go_quiet();
      send_op(op, next_gap(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : check_results
    itl_result_t want;
    if (rst_n && out_valid) begin
      if (lookup_answers.size() == 0) begin
        $display("%0t: result with no lookup pending, expected none, actual found %0b start %h",
                 $time, out_found, out_hit_start);
        errors++;
      end else begin
        want = lookup_answers.pop_front();
        check_field("found", word_t'(want.found), word_t'(out_found));
        check_field("hit_start", want.hit_start, out_hit_start);
        check_field("hit_end", want.hit_end, out_hit_end);
        check_field("info_address", want.info_address, out_info_address);
        if (want.found) n_hits++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d lookups pending", $time, lookup_answers.size());
      $display("interval_table_lookup_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int    mark, n, roll;
    word_t cval;

    row_expect(64'h0, 1'b0, 64'h0, 64'h0, 64'h0);
    row_expect(ALL1, 1'b0, 64'h0, 64'h0, 64'h0);
    row_write(0, 64'h0, 64'h100, 64'h0);
    row_write(1, 64'h100, 64'h200, 64'h1000);
    row_write(2, 64'h400, 64'h800, 64'h2000);
    row_write(3, 64'hFFFF_FFFF_FFFF_FF00, ALL1, ALL1);
    row_reg(REG_ENTRY_COUNT, 64'd4);
    row_expect(64'h0, 1'b1, 64'h0, 64'h100, 64'h0);
    row_expect(64'hFF, 1'b1, 64'h0, 64'h100, 64'h0);
    row_expect(64'h100, 1'b1, 64'h100, 64'h200, 64'h1000);
    row_expect(64'h200, 1'b0, 64'h0, 64'h0, 64'h0);
    row_expect(64'h7FF, 1'b1, 64'h400, 64'h800, 64'h2000);
    row_expect(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, ALL1, ALL1);
    row_expect(ALL1, 1'b0, 64'h0, 64'h0, 64'h0);
    row_reg(REG_SEGMENT_BASE, ALL1);
    row_lookup(64'hFF);
    row_lookup(64'h0);
    row_reg(REG_SEGMENT_BASE, 64'h8000_0000_0000_0000);
    row_lookup(64'h8000_0000_0000_0400);
    row_lookup(64'h7FFF_FFFF_FFFF_FFFF);
    // empty table
    row_reg(REG_ENTRY_COUNT, 64'd0);
    row_expect(64'h8000_0000_0000_0100, 1'b0, 64'h0, 64'h0, 64'h0);
    // overlapping entry breaks the sort order
    row_reg(REG_SEGMENT_BASE, 64'h0);
    row_write(1, 64'h50, 64'h900, 64'h3000);
    row_reg(REG_ENTRY_COUNT, 64'd3);
    row_lookup(64'h60);
    row_lookup(64'h850);
    row_lookup(64'h20);
    row_reg(REG_ENTRY_COUNT, 64'd1);
    row_lookup(64'h50);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else send_op(dir_rows[i].op, next_gap(), dir_rows[i].typed, dir_rows[i].want);
    end

    // outer search paths of the full depth, then counts at and above the depth
    burst = 1'b1;
    load_edge_paths();
    burst = 1'b0;
    write_reg(REG_SEGMENT_BASE, rand64());
    write_reg(REG_ENTRY_COUNT, word_t'(TBL_DEPTH));
    run_edge_lookups(20);
    write_reg(REG_ENTRY_COUNT, word_t'((1 << COUNT_W) - 1));
    run_edge_lookups(16);
    write_reg(REG_SEGMENT_BASE, ALL1);
    write_reg(REG_ENTRY_COUNT, (rand64() << COUNT_W) | word_t'(TBL_DEPTH + 1));
    run_edge_lookups(12);

    mark = ops_sent;
    while (ops_sent - mark < RAND_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 8) n = 0;
      else begin
        n = $urandom_range(1, 16);
        load_table(n, ($urandom_range(0, 9) < 2) ? 3 : $urandom_range(0, 2));
      end
      case ($urandom_range(0, 9))
        0, 1, 2: cval = '0;
        3: cval = ALL1;
        default: cval = rand64();
      endcase
      write_reg(REG_SEGMENT_BASE, cval);
      cval = word_t'(n);
      if ($urandom_range(0, 3) == 0) cval = cval | (rand64() << COUNT_W);
      write_reg(REG_ENTRY_COUNT, cval);
      run_lookups($urandom_range(4, 24));
    end

    go_quiet();
    repeat (TAIL_CYC) @(posedge clk);

    $display("ran %0d lookups (%0d hits), %0d entry writes, %0d register writes",
             n_lookups, n_hits, n_writes, n_regs);
    $display("tables sorted, scrambled and sparse at full depth, counts 0 to 2047, bases 0 to all ones");
    if (errors == 0) begin
      $display("interval_table_lookup_unit_tb OK");
    end else begin
      $display("interval_table_lookup_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/itl_pkg.sv
src/itl_table_mem.sv
src/itl_search.sv
src/interval_table_lookup_unit.sv
dv/interval_table_lookup_unit_tb.sv
